// ===== rtl/stc_pkg.sv =====
package stc_pkg;

	// Epoch year and its residues for the Gregorian leap rule
	localparam int EpochBaseYear = 2000;
	localparam logic [1:0] BaseMod4   = 2'(EpochBaseYear % 4);
	localparam logic [6:0] BaseMod100 = 7'(EpochBaseYear % 100);
	localparam logic [8:0] BaseMod400 = 9'(EpochBaseYear % 400);

	localparam logic [16:0] SecsPerDay  = 17'd86400;
	localparam logic [16:0] SecsPerHour = 17'd3600;
	localparam logic [16:0] SecsPerMin  = 17'd60;

	// Rounded-up reciprocals, scaled by 2^RecipShift, of the odd part of each
	// divisor: 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15
	localparam int RecipShift = 35;
	localparam logic [31:0] RecipDay  = 32'd50903317;
	localparam logic [31:0] RecipHour = 32'd152709949;
	localparam logic [31:0] RecipMin  = 32'd2290649225;

	// Multiply steps ahead of the remainder step for each split
	localparam logic [5:0] DivDaySteps  = 6'd1;
	localparam logic [5:0] DivHourSteps = 6'd1;
	localparam logic [5:0] DivMinSteps  = 6'd1;

	// Configuration register indexes
	localparam int CfgIdxW = 8;
	localparam logic [CfgIdxW-1:0] CfgZoneHours   = 8'd0;
	localparam logic [CfgIdxW-1:0] CfgEpochWeekday = 8'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_DAY,
		ST_DIV_HOUR,
		ST_DIV_MIN,
		ST_YEARS,
		ST_MONTHS,
		ST_DONE
	} ctl_state_t;

	// Which split the shared multiplier is working on
	typedef enum logic [1:0] {
		DS_DAY,
		DS_HOUR,
		DS_MIN
	} div_sel_t;

	typedef struct packed {
		logic load_day;
		logic div_step;
		logic latch_day;
		logic latch_hour;
		logic latch_min;
		logic year_step;
		logic month_step;
	} dp_cmd_t;

	typedef struct packed {
		logic year_done;
		logic month_done;
	} dp_sts_t;

	// Days in a month of a common year, month 0 is January
	function automatic logic [4:0] month_days(input logic [3:0] mon);
		logic [4:0] len;
		case (mon)
			4'd1: len = 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	// Remainder by seven of a small value, by conditional subtraction
	function automatic logic [2:0] mod7(input logic [5:0] x);
		logic [5:0] v;
		v = x;
		if (v >= 6'd56) v = v - 6'd56;
		if (v >= 6'd28) v = v - 6'd28;
		if (v >= 6'd14) v = v - 6'd14;
		if (v >= 6'd7)  v = v - 6'd7;
		return v[2:0];
	endfunction

endpackage

// ===== rtl/stc_ctrl.sv =====
module stc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  stc_pkg::dp_sts_t sts,
	output stc_pkg::dp_cmd_t cmd,
	output logic             busy,
	output logic             done
);

	stc_pkg::ctl_state_t state_q, state_d;
	logic [5:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stc_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			stc_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load_day = 1'b1;
					cnt_d        = stc_pkg::DivDaySteps;
					state_d      = stc_pkg::ST_DIV_DAY;
				end
			end
			stc_pkg::ST_DIV_DAY: begin
				if (cnt_q != '0) begin
					cmd.div_step = 1'b1;
					cnt_d        = cnt_q - 6'd1;
				end else begin
					cmd.latch_day = 1'b1;
					cnt_d         = stc_pkg::DivHourSteps;
					state_d       = stc_pkg::ST_DIV_HOUR;
				end
			end
			stc_pkg::ST_DIV_HOUR: begin
				if (cnt_q != '0) begin
					cmd.div_step = 1'b1;
					cnt_d        = cnt_q - 6'd1;
				end else begin
					cmd.latch_hour = 1'b1;
					cnt_d          = stc_pkg::DivMinSteps;
					state_d        = stc_pkg::ST_DIV_MIN;
				end
			end
			stc_pkg::ST_DIV_MIN: begin
				if (cnt_q != '0) begin
					cmd.div_step = 1'b1;
					cnt_d        = cnt_q - 6'd1;
				end else begin
					cmd.latch_min = 1'b1;
					state_d       = stc_pkg::ST_YEARS;
				end
			end
			stc_pkg::ST_YEARS: begin
				if (sts.year_done) state_d = stc_pkg::ST_MONTHS;
				else cmd.year_step = 1'b1;
			end
			stc_pkg::ST_MONTHS: begin
				if (sts.month_done) state_d = stc_pkg::ST_DONE;
				else cmd.month_step = 1'b1;
			end
			stc_pkg::ST_DONE: begin
				done    = 1'b1;
				state_d = stc_pkg::ST_IDLE;
			end
			default: state_d = stc_pkg::ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/stc_datapath.sv =====
module stc_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [stc_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [4:0]                  cfg_data,
	input  logic [31:0]                 epoch_seconds,
	input  stc_pkg::dp_cmd_t            cmd,
	output stc_pkg::dp_sts_t            sts,
	output logic [6:0]                  year_in_century,
	output logic [3:0]                  month_of_year,
	output logic [4:0]                  day_of_month,
	output logic [2:0]                  day_of_week,
	output logic [4:0]                  hour_of_day,
	output logic [5:0]                  minute_of_hour,
	output logic [5:0]                  second_of_minute
);

	logic signed [4:0] zone_hours_q;
	logic [2:0]  epoch_weekday_q;

	logic [31:0]       div_num_q;
	logic [15:0]       div_quo_q;
	stc_pkg::div_sel_t div_sel_q;

	logic [15:0] day_q;
	logic [3:0]  mon_q;
	logic [2:0]  wk_q;
	logic [6:0]  yic_q;
	logic [1:0]  m4_q;
	logic [6:0]  m100_q;
	logic [8:0]  m400_q;
	logic [4:0]  hour_q;
	logic [5:0]  min_q;
	logic [5:0]  sec_q;

	logic signed [16:0] zone_secs;
	logic [31:0] secs;
	logic [24:0] mul_a;
	logic [31:0] mul_b;
	logic [50:0] mul_p;
	logic [16:0] div_dvsr;
	logic [31:0] div_rem;
	logic        leap;
	logic [8:0]  ylen;
	logic [4:0]  mlen;
	logic [1:0]  ymod7;
	logic [2:0]  mmod7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_hours_q    <= '0;
			epoch_weekday_q <= 3'd7;
		end else if (cfg_we) begin
			if (cfg_index == stc_pkg::CfgZoneHours) zone_hours_q <= $signed(cfg_data);
			else if (cfg_index == stc_pkg::CfgEpochWeekday) epoch_weekday_q <= cfg_data[2:0];
		end
	end

	// Zone offset in seconds, wrapped into the 32-bit count
	assign zone_secs = zone_hours_q * $signed(stc_pkg::SecsPerHour);
	assign secs = epoch_seconds + {{15{zone_secs[16]}}, zone_secs};

	// Drop the power-of-two factor of the divisor, then multiply by the
	// reciprocal of the odd part
	always_comb begin
		case (div_sel_q)
			stc_pkg::DS_DAY: begin
				mul_a    = div_num_q[31:7];
				mul_b    = stc_pkg::RecipDay;
				div_dvsr = stc_pkg::SecsPerDay;
			end
			stc_pkg::DS_HOUR: begin
				mul_a    = {12'd0, div_num_q[16:4]};
				mul_b    = stc_pkg::RecipHour;
				div_dvsr = stc_pkg::SecsPerHour;
			end
			default: begin
				// minutes
				mul_a    = {15'd0, div_num_q[11:2]};
				mul_b    = stc_pkg::RecipMin;
				div_dvsr = stc_pkg::SecsPerMin;
			end
		endcase
	end

	assign mul_p   = {26'd0, mul_a} * {19'd0, mul_b};
	assign div_rem = div_num_q - ({16'd0, div_quo_q} * {15'd0, div_dvsr});

	assign leap = ((m4_q == 2'd0) && (m100_q != 7'd0)) || (m400_q == 9'd0);
	assign ylen = leap ? 9'd366 : 9'd365;
	assign ymod7 = leap ? 2'd2 : 2'd1;
	assign mlen = stc_pkg::month_days(mon_q) + {4'd0, (leap && (mon_q == 4'd1))};

	always_comb begin
		case (mlen)
			5'd29:   mmod7 = 3'd1;
			5'd30:   mmod7 = 3'd2;
			5'd31:   mmod7 = 3'd3;
			default: mmod7 = 3'd0;
		endcase
	end

	assign sts.year_done  = day_q < {7'd0, ylen};
	assign sts.month_done = (mon_q == 4'd11) || (day_q < {11'd0, mlen});

	always_ff @(posedge clk) begin
		if (cmd.load_day) begin
			div_num_q <= secs;
			div_sel_q <= stc_pkg::DS_DAY;
		end else if (cmd.div_step) begin
			div_quo_q <= 16'(mul_p >> stc_pkg::RecipShift);
		end else if (cmd.latch_day) begin
			div_num_q <= div_rem;
			div_sel_q <= stc_pkg::DS_HOUR;
		end else if (cmd.latch_hour) begin
			div_num_q <= div_rem;
			div_sel_q <= stc_pkg::DS_MIN;
		end

		if (cmd.latch_day) begin
			day_q  <= div_quo_q;
			mon_q  <= '0;
			wk_q   <= stc_pkg::mod7(6'(epoch_weekday_q) + 6'd6);
			yic_q  <= '0;
			m4_q   <= stc_pkg::BaseMod4;
			m100_q <= stc_pkg::BaseMod100;
			m400_q <= stc_pkg::BaseMod400;
		end else if (cmd.year_step) begin
			day_q  <= day_q - {7'd0, ylen};
			wk_q   <= stc_pkg::mod7(6'(wk_q) + 6'(ymod7));
			yic_q  <= (yic_q == 7'd99) ? 7'd0 : yic_q + 7'd1;
			m4_q   <= m4_q + 2'd1;
			m100_q <= (m100_q == 7'd99) ? 7'd0 : m100_q + 7'd1;
			m400_q <= (m400_q == 9'd399) ? 9'd0 : m400_q + 9'd1;
		end else if (cmd.month_step) begin
			day_q <= day_q - {11'd0, mlen};
			wk_q  <= stc_pkg::mod7(6'(wk_q) + 6'(mmod7));
			mon_q <= mon_q + 4'd1;
		end

		if (cmd.latch_hour) hour_q <= div_quo_q[4:0];
		if (cmd.latch_min) begin
			min_q <= div_quo_q[5:0];
			sec_q <= div_rem[5:0];
		end
	end

	assign year_in_century  = yic_q;
	assign month_of_year    = mon_q + 4'd1;
	assign day_of_month     = day_q[4:0] + 5'd1;
	assign day_of_week      = stc_pkg::mod7(6'(wk_q) + day_q[5:0]) + 3'd1;
	assign hour_of_day      = hour_q;
	assign minute_of_hour   = min_q;
	assign second_of_minute = sec_q;

endmodule

// ===== rtl/seconds_to_calendar_top.sv =====
// Epoch seconds to calendar date and time.
// Command channel: drive epoch_seconds and raise start; the transaction is
// taken at the clock edge where start is high and busy is low. busy stays
// high until the result has been shown.
// Result channel: done is high for exactly one cycle, and the seven fields
// are valid in that cycle; they hold until the next command is taken.
// The receiver cannot stall, so it must capture the result on done.
// Configuration: cfg_valid with cfg_index and cfg_data, always ready.
// Index 0 is zone_hours (signed whole hours), index 1 is epoch_weekday;
// other indexes are dropped. Write only while busy is low.
// One shared multiplier splits by reciprocal: a multiply step and then a
// remainder step for each of the day, hour and minute splits; then one
// year or one month is walked per cycle, and each walk ends in a step
// that sees it is done. The year walk covers up to 136 whole years and
// the month walk up to 11 whole months.
// A new command is taken the cycle after done.
// Reset: arst_n clears the controller to idle, zone_hours to 0 and
// epoch_weekday to 7 (Saturday).
module seconds_to_calendar_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [31:0]                 epoch_seconds,
	output logic                        done,
	output logic [6:0]                  year_in_century,
	output logic [3:0]                  month_of_year,
	output logic [4:0]                  day_of_month,
	output logic [2:0]                  day_of_week,
	output logic [4:0]                  hour_of_day,
	output logic [5:0]                  minute_of_hour,
	output logic [5:0]                  second_of_minute,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [stc_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [4:0]                  cfg_data
);

	stc_pkg::dp_cmd_t cmd;
	stc_pkg::dp_sts_t sts;

	// Registers accept a write in any cycle
	assign cfg_ready = 1'b1;

	stc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	stc_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.epoch_seconds    (epoch_seconds),
		.cmd              (cmd),
		.sts              (sts),
		.year_in_century  (year_in_century),
		.month_of_year    (month_of_year),
		.day_of_month     (day_of_month),
		.day_of_week      (day_of_week),
		.hour_of_day      (hour_of_day),
		.minute_of_hour   (minute_of_hour),
		.second_of_minute (second_of_minute)
	);

`ifndef NO_ASSERTIONS
	// A taken command keeps the block busy in the next cycle
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("busy not raised after command");

	// The result strobe lasts one cycle and only within a transaction
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy ##1 !done) else $error("done not a single busy cycle");

	// The result fields are in range when shown
	a_fields_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (month_of_year >= 4'd1 && month_of_year <= 4'd12 &&
			day_of_month >= 5'd1 && hour_of_day <= 5'd23 &&
			minute_of_hour <= 6'd59 && second_of_minute <= 6'd59 &&
			year_in_century <= 7'd99 && day_of_week >= 3'd1))
		else $error("result field out of range");

	// The date fields of the result are held stable in the cycle after done
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> ($stable(year_in_century) && $stable(month_of_year) &&
			$stable(day_of_month) && $stable(day_of_week)))
		else $error("result changed after done");
`endif

endmodule
